/* sv/bale_pkg.sv */
// ----------------------------------------------------------------------------
// bale_pkg - bounded array list engine definitions
// Sizes, command and status codes, cell controls and item structs.
// ----------------------------------------------------------------------------
`default_nettype none

package bale_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CAP_W  = 5;
  localparam int POS_W  = 4;
  localparam int CMD_W  = 4;

  localparam logic [CAP_W-1:0] CAPACITY_RST = CAP_W'(10);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR         = 4'd0,
    CMD_PUSH_BACK     = 4'd1,
    CMD_PUSH_FRONT    = 4'd2,
    CMD_INSERT_AT     = 4'd3,
    CMD_INSERT_SORTED = 4'd4,
    CMD_POP_AT        = 4'd5,
    CMD_POP_BACK      = 4'd6,
    CMD_POP_FRONT     = 4'd7,
    CMD_REMOVE        = 4'd8,
    CMD_FIND          = 4'd9,
    CMD_READ          = 4'd10
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_FROM_LEFT  = 2'd2,
    CELL_FROM_RIGHT = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  position;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [DATA_W-1:0] data_out;
    logic [CNT_W-1:0]  found_index;
    logic              found;
    logic [CNT_W-1:0]  count;
    logic              is_full;
    logic              is_empty;
  } res_t;

  typedef struct packed {
    logic eq;
    logic lt;
  } cell_flags_t;

endpackage

`default_nettype wire

/* sv/bale_cell.sv */
// ----------------------------------------------------------------------------
// bale_cell - one list entry
// Holds one value, compares it with the command value and loads from the
// command, its left neighbor or its right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module bale_cell (
  input  logic                  clk_i,
  input  bale_pkg::cell_op_e    op_i,
  input  logic [bale_pkg::DATA_W-1:0] value_i,
  input  logic [bale_pkg::DATA_W-1:0] left_i,
  input  logic [bale_pkg::DATA_W-1:0] right_i,
  output logic [bale_pkg::DATA_W-1:0] data_o,
  output bale_pkg::cell_flags_t flags_o
);
  import bale_pkg::*;

  logic [DATA_W-1:0] data_q, data_d;

  always_comb begin
    unique case (op_i)
      CELL_LOAD:       data_d = value_i;
      CELL_FROM_LEFT:  data_d = left_i;
      CELL_FROM_RIGHT: data_d = right_i;
      default:         data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o     = data_q;
  assign flags_o.eq = (data_q == value_i);
  assign flags_o.lt = (data_q < value_i);

endmodule

`default_nettype wire

/* sv/bounded_array_list_engine.sv */
// ----------------------------------------------------------------------------
// bounded_array_list_engine - ordered list of up to DEPTH values
// Command-driven list with insert, pop, remove, find and read.
// ----------------------------------------------------------------------------
// Each command taken with start high is finished at the edge that takes it: every entry
// sits in a cell that compares itself with the command value and shifts to
// or from its neighbors at the same edge, so busy stays low and a command
// may be issued every cycle. The result shows on res_o with done_o high for
// exactly one cycle, the cycle after the command; it is not held, so the
// receiver must take it then. The capacity register may be written any time
// the block is idle and takes effect on the next command.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_array_list_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  bale_pkg::req_t                req_i,
  output logic                          done_o,
  output bale_pkg::res_t                res_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bale_pkg::CAP_W-1:0]    cfg_data_i
);
  import bale_pkg::*;

  logic [CAP_W-1:0]  capacity_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              done_q;
  res_t              res_q, res_d;

  logic [DATA_W-1:0] cell_data [DEPTH];
  cell_flags_t       cell_flags [DEPTH];
  cell_op_e          cell_op [DEPTH];

  logic              acc;
  logic [CNT_W-1:0]  cap_lim;
  logic              full;
  logic [CNT_W-1:0]  pos_ext;
  logic [CNT_W-1:0]  match_idx;
  logic              match_any;
  logic [CNT_W-1:0]  sort_idx;
  logic [CNT_W-1:0]  k;
  logic              ins, pop, take;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign acc         = start && !busy;

  assign cap_lim = (CNT_W'(capacity_q) > CNT_W'(DEPTH)) ? CNT_W'(DEPTH)
                                                         : CNT_W'(capacity_q);
  assign full    = (count_q >= cap_lim);
  assign pos_ext = CNT_W'(req_i.position);

  always_comb begin
    match_idx = count_q;
    sort_idx  = CNT_W'(DEPTH);
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (CNT_W'(i) < count_q && cell_flags[i].eq) match_idx = CNT_W'(i);
      if (!(CNT_W'(i) < count_q && cell_flags[i].lt)) sort_idx = CNT_W'(i);
    end
  end

  assign match_any = (match_idx < count_q);

  always_comb begin
    ins     = 1'b0;
    pop     = 1'b0;
    take    = 1'b0;
    k       = '0;
    count_d = count_q;
    res_d   = '0;
    unique case (req_i.cmd) inside
      CMD_CLEAR: begin
        count_d = '0;
      end
      CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT_AT, CMD_INSERT_SORTED: begin
        if (full) begin
          res_d.status = ST_FULL;
        end else begin
          ins = 1'b1;
          case (req_i.cmd)
            CMD_PUSH_BACK:  k = count_q;
            CMD_PUSH_FRONT: k = '0;
            CMD_INSERT_AT: begin
              k = pos_ext;
              if (pos_ext > count_q) begin
                res_d.status = ST_BADPOS;
                ins          = 1'b0;
              end
            end
            default:        k = sort_idx;
          endcase
        end
      end
      CMD_POP_AT, CMD_POP_BACK, CMD_POP_FRONT: begin
        if (count_q == '0) begin
          res_d.status = ST_EMPTY;
        end else begin
          pop  = 1'b1;
          take = 1'b1;
          case (req_i.cmd)
            CMD_POP_AT: begin
              k = pos_ext;
              if (pos_ext >= count_q) begin
                res_d.status = ST_BADPOS;
                pop          = 1'b0;
                take         = 1'b0;
              end
            end
            CMD_POP_BACK: k = count_q - CNT_W'(1);
            default:      k = '0;
          endcase
        end
      end
      CMD_REMOVE: begin
        k           = match_idx;
        pop         = match_any;
        res_d.found = match_any;
      end
      CMD_FIND: begin
        res_d.found_index = match_idx;
        res_d.found       = match_any;
      end
      CMD_READ: begin
        k = pos_ext;
        if (pos_ext >= count_q) res_d.status = ST_BADPOS;
        else                    take = 1'b1;
      end
      default: begin
      end
    endcase
    if (ins) count_d = count_q + CNT_W'(1);
    if (pop) count_d = count_q - CNT_W'(1);
    if (take) res_d.data_out = cell_data[k[IDX_W-1:0]];
    res_d.count    = count_d;
    res_d.is_full  = (count_d >= cap_lim);
    res_d.is_empty = (count_d == '0);
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_op[i] = CELL_HOLD;
      if (acc && ins) begin
        if (CNT_W'(i) == k)     cell_op[i] = CELL_LOAD;
        else if (CNT_W'(i) > k) cell_op[i] = CELL_FROM_LEFT;
      end else if (acc && pop) begin
        if (CNT_W'(i) >= k) cell_op[i] = CELL_FROM_RIGHT;
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    bale_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[g]),
      .value_i (req_i.value),
      .left_i  ((g == 0) ? req_i.value : cell_data[(g == 0) ? 0 : g - 1]),
      .right_i ((g == DEPTH - 1) ? cell_data[g] : cell_data[(g == DEPTH - 1) ? g : g + 1]),
      .data_o  (cell_data[g]),
      .flags_o (cell_flags[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RST;
      count_q    <= '0;
      done_q     <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) capacity_q <= cfg_data_i;
      if (acc) count_q <= count_d;
      done_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef ASSERT_OFF
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("command without result");

  a_fail_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status != ST_OK) |-> (res_o.data_out == '0))
    else $error("failed command returned data");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.is_empty == (res_o.count == '0)))
    else $error("empty flag disagrees with count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("count beyond depth");
`endif

endmodule

`default_nettype wire

/* bench/tb_bounded_array_list_engine.sv */
// ----------------------------------------------------------------------------
// tb_bounded_array_list_engine - self-checking bench for the list engine
// Feeds directed and random list commands under several capacity settings,
// mirrors the list in a shadow copy and checks every result field by field.
// ----------------------------------------------------------------------------
module tb_bounded_array_list_engine;
  import bale_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SHOW_LIMIT  = 10;
  localparam int PHASES      = 12;
  localparam int PHASE_CMDS  = 115;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd11;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;

  typedef enum logic [1:0] {
    STEP_ITEM,
    STEP_CAPACITY,
    STEP_DRAIN
  } step_kind_e;

  typedef struct {
    step_kind_e       kind;
    req_t             item;
    logic [CAP_W-1:0] cap;
    int               gap;
  } step_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  req_t             cmd_item  = '0;
  logic             done;
  res_t             result;
  logic             cap_valid = 1'b0;
  logic             cap_ready;
  logic [CAP_W-1:0] cap_data  = '0;

  step_t             backlog[$];
  res_t              predicted[$];
  logic [DATA_W-1:0] shadow_list [DEPTH];
  int                shadow_count = 0;
  logic [CAP_W-1:0]  shadow_cap   = CAPACITY_RST;

  int n_sent, n_taken, n_cap_sent, n_cap_done;
  int hold_cycles, cycles, n_errors, n_checked;
  int status_seen [4];

  bounded_array_list_engine dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .busy        (busy),
    .req_i       (cmd_item),
    .done_o      (done),
    .res_o       (result),
    .cfg_valid_i (cap_valid),
    .cfg_ready_o (cap_ready),
    .cfg_data_i  (cap_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic res_t list_apply(req_t r);
    res_t res;
    int   lim;
    int   k;
    int   i;
    res = '0;
    lim = (int'(shadow_cap) > DEPTH) ? DEPTH : int'(shadow_cap);
    k   = -1;
    case (r.cmd)
      CMD_CLEAR: shadow_count = 0;
      CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT_AT, CMD_INSERT_SORTED: begin
        if (shadow_count >= lim) begin
          res.status = ST_FULL;
        end else if (r.cmd == CMD_PUSH_BACK) begin
          k = shadow_count;
        end else if (r.cmd == CMD_PUSH_FRONT) begin
          k = 0;
        end else if (r.cmd == CMD_INSERT_AT) begin
          if (int'(r.position) > shadow_count) res.status = ST_BADPOS;
          else k = int'(r.position);
        end else begin
          k = 0;
          while (k < shadow_count && shadow_list[k] < r.value) k++;
        end
        if (k >= 0) begin
          for (i = shadow_count; i > k; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[k] = r.value;
          shadow_count++;
        end
      end
      CMD_POP_AT, CMD_POP_BACK, CMD_POP_FRONT: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else if (r.cmd == CMD_POP_AT) begin
          if (int'(r.position) >= shadow_count) res.status = ST_BADPOS;
          else k = int'(r.position);
        end else if (r.cmd == CMD_POP_BACK) begin
          k = shadow_count - 1;
        end else begin
          k = 0;
        end
        if (k >= 0) begin
          res.data_out = shadow_list[k];
          for (i = k; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
          shadow_count--;
        end
      end
      CMD_REMOVE, CMD_FIND: begin
        k = 0;
        while (k < shadow_count && shadow_list[k] != r.value) k++;
        res.found = (k < shadow_count);
        if (r.cmd == CMD_FIND) begin
          res.found_index = CNT_W'(k);
        end else if (res.found) begin
          for (i = k; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
          shadow_count--;
        end
      end
      CMD_READ: begin
        if (int'(r.position) >= shadow_count) res.status = ST_BADPOS;
        else res.data_out = shadow_list[r.position];
      end
      default: ;
    endcase
    res.count    = CNT_W'(shadow_count);
    res.is_full  = (shadow_count >= lim);
    res.is_empty = (shadow_count == 0);
    return res;
  endfunction

  function automatic string fmt_res(res_t r);
    return $sformatf("st=%0d data=%h idx=%0d found=%b count=%0d full=%b empty=%b",
                     r.status, r.data_out, r.found_index, r.found, r.count,
                     r.is_full, r.is_empty);
  endfunction

  task automatic flag(string msg);
    n_errors++;
    if (n_errors <= SHOW_LIMIT) $display("%s", msg);
  endtask

  task automatic add_cmd(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value,
                         logic [POS_W-1:0] pos, int gap);
    step_t s;
    s.kind          = STEP_ITEM;
    s.item.cmd      = cmd;
    s.item.value    = value;
    s.item.position = pos;
    s.cap           = '0;
    s.gap           = gap;
    backlog.insert(backlog.size(), s);
  endtask

  task automatic add_capacity(logic [CAP_W-1:0] cap);
    step_t s;
    s.kind = STEP_DRAIN;
    s.item = '0;
    s.cap  = '0;
    s.gap  = 0;
    backlog.insert(backlog.size(), s);
    s.kind = STEP_CAPACITY;
    s.cap  = cap;
    s.gap  = $urandom_range(0, 19);
    backlog.insert(backlog.size(), s);
  endtask

  task automatic add_random_cmd(int gap);
    int                r;
    logic [CMD_W-1:0]  c;
    logic [DATA_W-1:0] v;
    logic [POS_W-1:0]  p;
    r = $urandom_range(0, 99);
    if (r < 3) c = CMD_CLEAR;
    else if (r < 18) c = CMD_PUSH_BACK;
    else if (r < 28) c = CMD_PUSH_FRONT;
    else if (r < 38) c = CMD_INSERT_AT;
    else if (r < 50) c = CMD_INSERT_SORTED;
    else if (r < 60) c = CMD_POP_AT;
    else if (r < 67) c = CMD_POP_BACK;
    else if (r < 74) c = CMD_POP_FRONT;
    else if (r < 82) c = CMD_REMOVE;
    else if (r < 90) c = CMD_FIND;
    else if (r < 98) c = CMD_READ;
    else c = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    r = $urandom_range(0, 9);
    if (r < 5) v = $urandom_range(0, 7);
    else if (r == 5) v = '1;
    else if (r == 6) v = '0;
    else v = $urandom;
    p = POS_W'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 3));
    add_cmd(c, v, p, gap);
  endtask

  // drive on the falling edge; hold each item until the monitor counts it
  always @(negedge clk) begin : drive
    logic  nx_start;
    logic  nx_cap;
    step_t s;
    nx_start = start;
    nx_cap   = cap_valid;
    if (rst_n) begin
      if (start && n_taken == n_sent) nx_start = 1'b0;
      if (cap_valid && n_cap_done == n_cap_sent) nx_cap = 1'b0;
      if (!nx_start && !nx_cap) begin
        if (hold_cycles > 0) begin
          hold_cycles--;
        end else if (backlog.size() > 0) begin
          s = backlog[0];
          case (s.kind)
            STEP_ITEM: begin
              backlog.delete(0);
              nx_start    = 1'b1;
              cmd_item   <= s.item;
              n_sent++;
              hold_cycles = s.gap;
            end
            STEP_CAPACITY: begin
              if (predicted.size() == 0) begin
                backlog.delete(0);
                nx_cap      = 1'b1;
                cap_data   <= s.cap;
                n_cap_sent++;
                hold_cycles = s.gap;
              end
            end
            default: begin
              if (predicted.size() == 0) backlog.delete(0);
            end
          endcase
        end
      end
    end
    start     <= nx_start;
    cap_valid <= nx_cap;
  end

  // sample on the rising edge: check results, then record new items and writes
  always @(posedge clk) begin : watch
    res_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, predicted.size());
      $display("tb: failure");
      $finish;
    end else if (rst_n) begin
      if (done) begin
        if (predicted.size() == 0) begin
          flag($sformatf("unexpected result: %s", fmt_res(result)));
        end else begin
          want = predicted[0];
          predicted.delete(0);
          n_checked++;
          status_seen[want.status]++;
          if (result.status !== want.status || result.data_out !== want.data_out ||
              result.found_index !== want.found_index || result.found !== want.found ||
              result.count !== want.count || result.is_full !== want.is_full ||
              result.is_empty !== want.is_empty)
            flag($sformatf("result %0d mismatch\n  exp %s\n  got %s",
                           n_checked, fmt_res(want), fmt_res(result)));
        end
      end
      if (start && !busy) begin
        predicted.insert(predicted.size(), list_apply(cmd_item));
        n_taken <= n_taken + 1;
      end
      if (cap_valid && cap_ready) begin
        shadow_cap = cap_data;
        n_cap_done <= n_cap_done + 1;
      end
    end
  end

  initial begin
    logic [CAP_W-1:0] cap_plan [PHASES];
    int               mode;
    int               g;
    cap_plan = '{5'd16, 5'd2, 5'd1, 5'd0, 5'd31, 5'd17, 5'd5, 5'd16, 5'd10, 5'd3,
                 5'd8, 5'd12};
    cap_plan[PHASES-1] = CAP_W'($urandom_range(1, 16));

    add_cmd(CMD_POP_BACK, '0, 4'd0, 0);
    add_cmd(CMD_POP_FRONT, '0, 4'd0, 3);
    add_cmd(CMD_POP_AT, '0, 4'd0, 0);
    add_cmd(CMD_READ, '0, 4'd0, 1);
    add_cmd(CMD_REMOVE, '0, 4'd0, 0);
    add_cmd(CMD_FIND, '0, 4'd0, 0);
    add_cmd(CMD_INSERT_AT, 32'd1, 4'd1, 0);
    add_cmd(CMD_PUSH_BACK, 32'h0000_0000, 4'd0, 0);
    add_cmd(CMD_PUSH_BACK, 32'hFFFF_FFFF, 4'd0, 2);
    add_cmd(CMD_PUSH_FRONT, 32'd5, 4'd0, 0);
    add_cmd(CMD_INSERT_AT, 32'hAAAA_5555, 4'd3, 0);
    add_cmd(CMD_INSERT_SORTED, 32'd7, 4'd15, 0);
    add_cmd(CMD_FIND, 32'd7, 4'd0, 0);
    add_cmd(CMD_FIND, 32'h1234_5678, 4'd0, 19);
    add_cmd(CMD_READ, '0, 4'd15, 0);
    add_cmd(CMD_REMOVE, 32'd7, 4'd0, 0);
    add_cmd(CMD_REMOVE, 32'd9, 4'd0, 0);
    add_cmd(CMD_POP_AT, '0, 4'd15, 0);
    add_cmd(CMD_POP_AT, '0, 4'd1, 0);
    add_cmd(CMD_SPARE_LO, 32'h5555_AAAA, 4'd10, 0);
    add_cmd(CMD_SPARE_HI, '1, 4'd15, 0);
    add_cmd(CMD_CLEAR, '0, 4'd0, 0);
    add_capacity(5'd1);
    add_cmd(CMD_PUSH_BACK, 32'd1, 4'd0, 0);
    add_cmd(CMD_PUSH_FRONT, 32'd2, 4'd0, 0);
    add_cmd(CMD_INSERT_AT, 32'd3, 4'd15, 0);
    add_cmd(CMD_POP_AT, '0, 4'd15, 0);

    for (int ph = 0; ph < PHASES; ph++) begin
      add_capacity(cap_plan[ph]);
      mode = ph % 3;
      for (int n = 0; n < PHASE_CMDS; n++) begin
        if (mode == 0) g = 0;
        else if (mode == 1) g = $urandom_range(0, 19);
        else g = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
        add_random_cmd(g);
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (backlog.size() > 0 || start || cap_valid) @(posedge clk);
    while (predicted.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("checked %0d results across %0d capacity writes, %0d errors",
             n_checked, n_cap_done, n_errors);
    $display("status mix ok/full/empty/badpos: %0d/%0d/%0d/%0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_BADPOS]);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
